/* rtl/core/awh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awh_pkg
// Types and constants shared by the archive block header walker.
// ----------------------------------------------------------------------------
package awh_pkg;

   localparam int POS_W    = 48;
   localparam int VAL_W    = 64;
   localparam int OQ_DEPTH = 4;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [1:0] STATUS_BLOCK     = 2'd0;
   localparam logic [1:0] STATUS_OVERRUN   = 2'd1;
   localparam logic [1:0] STATUS_CLEAN_END = 2'd2;
   localparam logic [1:0] STATUS_CUT_END   = 2'd3;

   typedef enum logic [2:0] {
      PH_SIG   = 3'd0,
      PH_CSUM  = 3'd1,
      PH_HSIZE = 3'd2,
      PH_TYPE  = 3'd3,
      PH_FLAGS = 3'd4,
      PH_EXTRA = 3'd5,
      PH_DATA  = 3'd6,
      PH_SKIP  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [POS_W-1:0] block_start;
      logic [VAL_W-1:0] block_type;
      logic [VAL_W-1:0] block_flags;
      logic [VAL_W-1:0] extra_size;
      logic [VAL_W-1:0] data_size;
      logic [POS_W-1:0] header_end;
      logic             size_overflow;
      logic             is_last;
   } rsp_type;

endpackage

/* rtl/core/archive_block_header_walker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_block_header_walker
// Walks an archive byte stream, decodes block header fields and reports blocks.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one file byte per beat, with end_of_file set on the last byte.
//   rsp_ carries block records and end-of-file reports. A byte causes zero,
//   one or two result beats; is_last marks the final beat caused by a byte.
//   Each accepted byte is decoded in the cycle it is accepted; its results sit
//   in a four-entry output queue and appear on rsp_ in the following cycle at
//   the earliest. Throughput is one byte per cycle while req_ready is high;
//   req_ready stays high while at least two queue entries are free, so the
//   results of an accepted byte always fit in the queue.
//   When the receiver stalls, the queue fills and req_ready drops; nothing is
//   lost. Reset empties the queue and returns the walker to the signature
//   skip at offset zero; every end_of_file byte also returns the walker there,
//   keeping the queued results, so the next byte is taken as the first byte
//   of a new file.
// ----------------------------------------------------------------------------
module archive_block_header_walker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  awh_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output awh_pkg::rsp_type  rsp_data
);
   import awh_pkg::*;

   function automatic logic [POS_W:0] sat_add(input logic [POS_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      begin
         s = {1'b0, b} + {{(VAL_W + 1 - POS_W){1'b0}}, a};
         if (|s[VAL_W:POS_W]) begin
            sat_add = {1'b1, POS_MAX};
         end else begin
            sat_add = {1'b0, s[POS_W-1:0]};
         end
      end
   endfunction

   function automatic rsp_type mk_rsp(input logic [1:0]       st,
                                      input logic             rec,
                                      input logic [POS_W-1:0] bstart,
                                      input logic [VAL_W-1:0] btype,
                                      input logic [VAL_W-1:0] bflags,
                                      input logic [VAL_W-1:0] bextra,
                                      input logic [VAL_W-1:0] bdata,
                                      input logic [POS_W-1:0] hend,
                                      input logic             ovf);
      rsp_type r;
      begin
         r               = '0;
         r.status        = st;
         if (rec) begin
            r.block_start   = bstart;
            r.block_type    = btype;
            r.block_flags   = bflags;
            r.extra_size    = bextra;
            r.data_size     = bdata;
            r.header_end    = hend;
            r.size_overflow = ovf;
         end
         mk_rsp = r;
      end
   endfunction

   // Walker state.
   logic [POS_W-1:0] pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [6:0]       shift_ff, shift_in;
   logic             ovf_ff, ovf_in;
   logic [POS_W-1:0] bstart_ff, bstart_in;
   logic [POS_W-1:0] hend_ff, hend_in;
   logic [VAL_W-1:0] type_ff, type_in;
   logic [VAL_W-1:0] flags_ff, flags_in;
   logic [VAL_W-1:0] extra_ff, extra_in;
   logic [POS_W-1:0] skip_ff, skip_in;

   // Output queue.
   rsp_type          oq_mem [OQ_DEPTH];
   logic [OQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OQ_CW-1:0] count_ff, count_in;

   logic             req_fire, rsp_fire;
   logic             stuck;
   logic [POS_W-1:0] npos;
   logic [6:0]       part;
   logic [VAL_W+6:0] part_wide;
   logic [VAL_W-1:0] acc_abs;
   logic [6:0]       shift_abs;
   logic             absorb_ovf;
   logic [VAL_W-1:0] hsz_val, data_sel;
   logic [POS_W:0]   hsz_sum, tgt_sum;

   logic             hdr_done, hend_fresh, st_eof;
   logic [VAL_W-1:0] data_v;
   logic [1:0]       n_res;
   rsp_type          res0, res1, rec_eof, end_eof;

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign req_ready = (count_ff <= OQ_CW'(OQ_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = oq_mem[rd_ptr_ff];

   assign stuck = (pos_ff == POS_MAX);
   assign npos  = stuck ? pos_ff : pos_ff + 1'b1;

   // Seven payload bits of a length byte, placed at the current shift. Bits
   // pushed past bit 63 saturate the value.
   assign part      = req_data.byte_value[6:0];
   assign part_wide = {{VAL_W{1'b0}}, part} << shift_ff[5:0];

   always_comb begin
      acc_abs    = acc_ff;
      shift_abs  = shift_ff;
      absorb_ovf = 1'b0;
      if (!shift_ff[6]) begin
         acc_abs = acc_ff | part_wide[VAL_W-1:0];
         if (|part_wide[VAL_W+6:VAL_W]) begin
            acc_abs    = {VAL_W{1'b1}};
            absorb_ovf = 1'b1;
         end
         shift_abs = (shift_ff > 7'd57) ? 7'd64 : shift_ff + 7'd7;
      end else if (part != '0) begin
         acc_abs    = {VAL_W{1'b1}};
         absorb_ovf = 1'b1;
      end
   end

   assign hsz_val  = (phase_ff == PH_HSIZE) ? acc_abs : '0;
   assign data_sel = (phase_ff == PH_DATA) ? acc_abs : '0;
   assign hsz_sum  = sat_add(npos, hsz_val);
   assign tgt_sum  = sat_add(hend_ff, data_sel);

   always_comb begin
      pos_in     = pos_ff;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      shift_in   = shift_ff;
      ovf_in     = ovf_ff;
      bstart_in  = bstart_ff;
      hend_in    = hend_ff;
      type_in    = type_ff;
      flags_in   = flags_ff;
      extra_in   = extra_ff;
      skip_in    = skip_ff;
      hdr_done   = 1'b0;
      hend_fresh = 1'b0;
      st_eof     = 1'b0;
      data_v     = '0;
      n_res      = 2'd0;
      res0       = '0;
      res1       = '0;
      rec_eof    = '0;
      end_eof    = '0;

      if (req_fire) begin
         case (phase_ff)
            PH_SIG: begin
               if (cnt_ff >= 3'd7) begin
                  phase_in = PH_CSUM;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_CSUM: begin
               if (cnt_ff == '0) begin
                  bstart_in = pos_ff;
                  ovf_in    = 1'b0;
                  hend_in   = '0;
                  type_in   = '0;
                  flags_in  = '0;
                  extra_in  = '0;
               end
               if (cnt_ff >= 3'd3) begin
                  phase_in = PH_HSIZE;
                  cnt_in   = '0;
                  acc_in   = '0;
                  shift_in = '0;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            PH_SKIP: begin
               if (npos >= skip_ff) begin
                  phase_in = PH_CSUM;
                  cnt_in   = '0;
               end
            end
            default: begin
               acc_in   = acc_abs;
               shift_in = shift_abs;
               ovf_in   = ovf_in | absorb_ovf;
               if (!req_data.byte_value[7]) begin
                  acc_in   = '0;
                  shift_in = '0;
                  case (phase_ff)
                     PH_HSIZE: begin
                        hend_in    = hsz_sum[POS_W-1:0];
                        ovf_in     = ovf_in | hsz_sum[POS_W];
                        hend_fresh = 1'b1;
                        phase_in   = PH_TYPE;
                     end
                     PH_TYPE: begin
                        type_in  = acc_abs;
                        phase_in = PH_FLAGS;
                     end
                     PH_FLAGS: begin
                        flags_in = acc_abs;
                        if (acc_abs[0]) begin
                           phase_in = PH_EXTRA;
                        end else if (acc_abs[1]) begin
                           phase_in = PH_DATA;
                        end else begin
                           hdr_done = 1'b1;
                        end
                     end
                     PH_EXTRA: begin
                        extra_in = acc_abs;
                        if (flags_ff[1]) begin
                           phase_in = PH_DATA;
                        end else begin
                           hdr_done = 1'b1;
                        end
                     end
                     default: begin
                        data_v   = acc_abs;
                        hdr_done = 1'b1;
                     end
                  endcase
               end
            end
         endcase

         if (stuck && phase_ff != PH_SIG) begin
            ovf_in = 1'b1;
         end

         // A finished header is checked against the header end held in the
         // register; it never changes in the beat that completes the header.
         if (hdr_done) begin
            ovf_in = ovf_in | tgt_sum[POS_W];
            res0   = mk_rsp((npos > hend_ff) ? STATUS_OVERRUN : STATUS_BLOCK, 1'b1,
                            bstart_in, type_in, flags_in, extra_in, data_v,
                            hend_in, ovf_in);
            n_res  = 2'd1;
            if (tgt_sum[POS_W-1:0] > npos) begin
               phase_in = PH_SKIP;
               skip_in  = tgt_sum[POS_W-1:0];
            end else begin
               phase_in = PH_CSUM;
               cnt_in   = '0;
            end
         end

         pos_in = npos;

         if (req_data.end_of_file) begin
            if (phase_ff == PH_SIG || (phase_ff == PH_CSUM && cnt_ff < 3'd3)) begin
               res0  = mk_rsp(STATUS_CLEAN_END, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0);
               n_res = 2'd1;
            end else if (hdr_done || phase_ff == PH_SKIP) begin
               end_eof = mk_rsp((phase_in == PH_SKIP) ? STATUS_CUT_END : STATUS_CLEAN_END,
                                1'b0, '0, '0, '0, '0, '0, '0, 1'b0);
               if (hdr_done) begin
                  res1  = end_eof;
                  n_res = 2'd2;
               end else begin
                  res0  = end_eof;
                  n_res = 2'd1;
               end
            end else begin
               // File cut inside the header: report the partial field.
               case (phase_in)
                  PH_HSIZE: begin
                     hend_in    = hsz_sum[POS_W-1:0];
                     ovf_in     = ovf_in | hsz_sum[POS_W];
                     hend_fresh = 1'b1;
                  end
                  PH_TYPE:  type_in  = acc_in;
                  PH_FLAGS: flags_in = acc_in;
                  PH_EXTRA: extra_in = acc_in;
                  PH_DATA:  data_v   = acc_in;
                  default:  data_v   = '0;
               endcase
               // A header end computed from the current offset is never
               // below it, so only a registered one can be overrun.
               st_eof  = !hend_fresh && (npos > hend_ff);
               rec_eof = mk_rsp(st_eof ? STATUS_OVERRUN : STATUS_BLOCK, 1'b1,
                                bstart_in, type_in, flags_in, extra_in, data_v,
                                hend_in, ovf_in);
               res0    = rec_eof;
               res1    = mk_rsp(STATUS_CUT_END, 1'b0, '0, '0, '0, '0, '0, '0, 1'b0);
               n_res   = 2'd2;
            end

            pos_in    = '0;
            phase_in  = PH_SIG;
            cnt_in    = '0;
            acc_in    = '0;
            shift_in  = '0;
            ovf_in    = 1'b0;
            bstart_in = '0;
            hend_in   = '0;
            type_in   = '0;
            flags_in  = '0;
            extra_in  = '0;
            skip_in   = '0;
         end

         if (n_res == 2'd1) begin
            res0.is_last = 1'b1;
         end
         if (n_res == 2'd2) begin
            res1.is_last = 1'b1;
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OQ_AW'(n_res);
      rd_ptr_in = rd_ptr_ff + OQ_AW'(rsp_fire);
      count_in  = count_ff + OQ_CW'(n_res) - OQ_CW'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (n_res != 2'd0) begin
         oq_mem[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         oq_mem[wr_ptr_ff + OQ_AW'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         phase_ff  <= PH_SIG;
         cnt_ff    <= '0;
         acc_ff    <= '0;
         shift_ff  <= '0;
         ovf_ff    <= 1'b0;
         bstart_ff <= '0;
         hend_ff   <= '0;
         type_ff   <= '0;
         flags_ff  <= '0;
         extra_ff  <= '0;
         skip_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         acc_ff    <= acc_in;
         shift_ff  <= shift_in;
         ovf_ff    <= ovf_in;
         bstart_ff <= bstart_in;
         hend_ff   <= hend_in;
         type_ff   <= type_in;
         flags_ff  <= flags_in;
         extra_ff  <= extra_in;
         skip_ff   <= skip_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
